FILE: hdl/rtwc_pkg.sv
// route time window check: shared types and constants
// no dependencies, imported by rtwc_stop_eval and route_time_window_check
package rtwc_pkg;

   localparam int TIME_INT_BITS  = 16;
   localparam int TIME_FRAC_BITS = 8;
   localparam int TIME_W         = TIME_INT_BITS + TIME_FRAC_BITS;
   localparam int LOAD_W         = 16;
   localparam int REM_W          = LOAD_W + 1;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = TIME_W;
   localparam int REQ_DATA_W     = 5 * TIME_W + LOAD_W;
   localparam int RSP_DATA_W     = 32;

   localparam logic [LOAD_W-1:0] CAPACITY_RESET  = LOAD_W'(200);
   localparam logic [TIME_W-1:0] DEPOT_DUE_RESET = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VEHICLE_CAPACITY = 1'b0,
      CSR_DEPOT_DUE_TIME   = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [TIME_W-1:0] travel_time;
      logic [TIME_W-1:0] ready_time;
      logic [TIME_W-1:0] service_time;
      logic [TIME_W-1:0] due_time;
      logic [LOAD_W-1:0] stop_demand;
      logic [TIME_W-1:0] return_time;
      logic              first_stop;
      logic              last_stop;
   } stop_type;

   typedef struct packed {
      logic              feasible;
      logic [TIME_W-1:0] route_time;
   } result_type;

   typedef struct packed {
      logic [LOAD_W-1:0] vehicle_capacity;
      logic [TIME_W-1:0] depot_due_time;
   } cfg_type;

endpackage

FILE: hdl/route_time_window_check.sv
// route time window check top level: input register, stop evaluation, result register
// depends on rtwc_pkg and rtwc_stop_eval
//
//  channel | dir | beat contents
//  req_    | in  | one route stop, tuser = first stop, tlast = last stop
//  rsp_    | out | one route verdict per last stop
//  csr_    | in  | register write, 0 capacity, 1 depot due time
//
// one stop per cycle unless a last stop waits, verdict via the input register, then the result register
// the running time and load loop is combinational and closes through the state registers
// synchronous reset clears route state, valids and restores register defaults
// a last stop waits in the input register only while a verdict is held unclaimed
module route_time_window_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // travel_time, ready_time, service_time, due_time, stop_demand, return_time
   input  logic [rtwc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // first_stop
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // feasible, route_time, zero fill
   output logic [rtwc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [rtwc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rtwc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rtwc_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       in_vld_ff, in_vld_in;
   stop_type   in_ff, in_in;
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, out_in;
   result_type result;
   stop_type   req_stop;
   logic       accept;
   logic       advance;

   assign req_stop.travel_time  = req_tdata[TIME_W-1:0];
   assign req_stop.ready_time   = req_tdata[2*TIME_W-1:TIME_W];
   assign req_stop.service_time = req_tdata[3*TIME_W-1:2*TIME_W];
   assign req_stop.due_time     = req_tdata[4*TIME_W-1:3*TIME_W];
   assign req_stop.stop_demand  = req_tdata[4*TIME_W+LOAD_W-1:4*TIME_W];
   assign req_stop.return_time  = req_tdata[5*TIME_W+LOAD_W-1:4*TIME_W+LOAD_W];
   assign req_stop.first_stop   = req_tuser;
   assign req_stop.last_stop    = req_tlast;

   assign advance    = in_vld_ff && (!in_ff.last_stop || !out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign accept     = req_tvalid && req_tready;

   rtwc_stop_eval u_stop_eval (
      .clock    (clock),
      .reset    (reset),
      .stop_vld (advance),
      .stop     (in_ff),
      .cfg      (cfg_ff),
      .result   (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_index))
            CSR_VEHICLE_CAPACITY: cfg_in.vehicle_capacity = csr_wdata[LOAD_W-1:0];
            CSR_DEPOT_DUE_TIME:   cfg_in.depot_due_time   = csr_wdata[TIME_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end

      in_in     = accept ? req_stop : in_ff;
      in_vld_in = accept ? 1'b1 : (advance ? 1'b0 : in_vld_ff);

      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (advance && in_ff.last_stop) begin
         out_in     = result;
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vehicle_capacity <= CAPACITY_RESET;
         cfg_ff.depot_due_time   <= DEPOT_DUE_RESET;
         in_vld_ff               <= 1'b0;
         out_vld_ff              <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-TIME_W-1){1'b0}}, out_ff.route_time, out_ff.feasible};

   a_infeasible_zero_time: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_ff.feasible) |-> (out_ff.route_time == '0))
      else $error("infeasible verdict carries a route time");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_vld_ff && in_ff.last_stop && out_vld_ff && !rsp_tready))
      else $error("input stalled without a blocked verdict");

   a_verdict_from_last: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && rsp_tready && !(in_vld_ff && in_ff.last_stop)) |=> !out_vld_ff)
      else $error("verdict produced without a last stop");

endmodule

FILE: hdl/rtwc_stop_eval.sv
// route time window check: per-stop evaluation and route state registers
// depends on rtwc_pkg
module rtwc_stop_eval (
   input  logic               clock,
   input  logic               reset,
   input  logic               stop_vld,
   input  rtwc_pkg::stop_type stop,
   input  rtwc_pkg::cfg_type  cfg,
   output rtwc_pkg::result_type result
);
   import rtwc_pkg::*;

   logic [TIME_W-1:0]       elapsed_ff, elapsed_in;
   logic signed [REM_W-1:0] load_ff, load_in;
   logic                    failed_ff, failed_in;

   logic [TIME_W-1:0]       elapsed_base;
   logic signed [REM_W-1:0] load_base;
   logic                    failed_base;
   logic signed [REM_W:0]   load_diff;
   logic signed [REM_W-1:0] load_next;
   logic [TIME_W:0]         arrive_sum;
   logic [TIME_W-1:0]       arrive;
   logic [TIME_W-1:0]       start;
   logic [TIME_W:0]         finish_sum;
   logic [TIME_W-1:0]       finish;
   logic [TIME_W:0]         back_sum;
   logic                    fail_stop;
   logic                    fail_route;

   always_comb begin
      elapsed_base = stop.first_stop ? '0 : elapsed_ff;
      load_base    = stop.first_stop ? $signed({1'b0, cfg.vehicle_capacity}) : load_ff;
      failed_base  = stop.first_stop ? 1'b0 : failed_ff;

      // load saturates at the most negative value
      load_diff = {load_base[REM_W-1], load_base} - $signed({2'b00, stop.stop_demand});
      if (load_diff[REM_W] != load_diff[REM_W-1]) begin
         load_next = {1'b1, {(REM_W-1){1'b0}}};
      end else begin
         load_next = load_diff[REM_W-1:0];
      end

      arrive_sum = {1'b0, elapsed_base} + {1'b0, stop.travel_time};
      arrive     = arrive_sum[TIME_W] ? '1 : arrive_sum[TIME_W-1:0];
      start      = (arrive < stop.ready_time) ? stop.ready_time : arrive;
      finish_sum = {1'b0, start} + {1'b0, stop.service_time};
      finish     = finish_sum[TIME_W] ? '1 : finish_sum[TIME_W-1:0];
      back_sum   = {1'b0, finish} + {1'b0, stop.return_time};

      fail_stop  = failed_base | (finish > stop.due_time) | load_next[REM_W-1];
      fail_route = fail_stop | (back_sum > {1'b0, cfg.depot_due_time});

      result.feasible   = ~fail_route;
      result.route_time = fail_route ? '0 : finish;

      elapsed_in = elapsed_ff;
      load_in    = load_ff;
      failed_in  = failed_ff;
      if (stop_vld) begin
         elapsed_in = finish;
         load_in    = load_next;
         failed_in  = stop.last_stop ? fail_route : fail_stop;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         load_ff    <= '0;
         failed_ff  <= 1'b0;
      end else begin
         elapsed_ff <= elapsed_in;
         load_ff    <= load_in;
         failed_ff  <= failed_in;
      end
   end

   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !(stop_vld && stop.first_stop)) |=> failed_ff)
      else $error("failure mark cleared without a route start");

   a_short_load_fails: assert property (@(posedge clock) disable iff (reset)
      (stop_vld && load_next[REM_W-1]) |=> failed_ff)
      else $error("negative load did not mark the route failed");

endmodule
